// ===== rtl/core/dotp_pkg.sv =====
// Shared types and constants of the DHCP option TLV parser.
package dotp_pkg;

  localparam int MAX_VALUE_BYTES_DEF = 2048;

  // Depth of the result buffer in front of the output channel
  localparam int OB_DEPTH = 4;
  // Most results one input item can cause
  localparam int MAX_RES = 3;

  localparam logic [2:0] KIND_OPTION    = 3'd0;
  localparam logic [2:0] KIND_AGENT     = 3'd1;
  localparam logic [2:0] KIND_AGENT_END = 3'd2;
  localparam logic [2:0] KIND_VALID     = 3'd3;
  localparam logic [2:0] KIND_INVALID   = 3'd4;

  localparam logic [7:0] CODE_PAD   = 8'd0;
  localparam logic [7:0] CODE_AGENT = 8'd82;
  localparam logic [7:0] CODE_END   = 8'd255;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  option_code;
    logic [7:0]  value_byte;
    logic [10:0] value_offset;
    logic        agent_malformed;
    logic        last;
  } res_t;

endpackage

// ===== rtl/core/dotp_out_buf.sv =====
// Result buffer: takes up to three results per cycle, gives out one per cycle while out_tready is high.
module dotp_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_cnt,
  input  dotp_pkg::res_t push_res [dotp_pkg::MAX_RES],
  output logic          room,
  output logic          out_tvalid,
  input  logic          out_tready,
  output dotp_pkg::res_t head
);
  import dotp_pkg::*;

  localparam int CntW = $clog2(OB_DEPTH + 1);

  res_t           slot_r   [OB_DEPTH];
  res_t           slot_nxt [OB_DEPTH];
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic           pop;
  logic [CntW-1:0] base;
  logic [CntW-1:0] rel;
  res_t           shifted  [OB_DEPTH];

  assign pop        = (cnt_r != '0) && out_tready;
  assign base       = cnt_r - CntW'(pop);
  assign out_tvalid = (cnt_r != '0);
  assign head       = slot_r[0];
  // room for a full burst of results from the next item
  assign room       = (cnt_r <= CntW'(OB_DEPTH - MAX_RES));

  always_comb begin
    for (int i = 0; i < OB_DEPTH - 1; i++) begin
      shifted[i] = pop ? slot_r[i+1] : slot_r[i];
    end
    shifted[OB_DEPTH-1] = slot_r[OB_DEPTH-1];
    for (int i = 0; i < OB_DEPTH; i++) begin
      rel         = CntW'(i) - base;
      slot_nxt[i] = shifted[i];
      if ((CntW'(i) >= base) && (rel < CntW'(push_cnt))) begin
        slot_nxt[i] = push_res[rel[1:0]];
      end
    end
    cnt_nxt = base + CntW'(push_cnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < OB_DEPTH; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

endmodule

// ===== rtl/core/dhcp_option_tlv_parser_top.sv =====
// Top level of the DHCP option TLV parser: record parsing and length table.
// Results are registered in the result buffer before they reach the output.
// Throughput: one item per cycle while items cause at most one result each and out_tready
//   stays high; the results of an item leave the output in order, and in_tready
//   drops while more than one result waits in the four-entry result buffer.
// Reset (rst_n, synchronous): clears the parser state, the per-code valid bits and the
//   result buffer; the length memory is not cleared, the valid bits mask its contents.
module dhcp_option_tlv_parser_top #(
  parameter int MAX_VALUE_BYTES = dotp_pkg::MAX_VALUE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] new_packet
  input  logic        in_tlast,   // last_of_buffer
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] option_code, [15:8] value_byte,
                                  // [26:16] value_offset, [27] agent_malformed, zero above
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast   // last result of the input item
);
  import dotp_pkg::*;

  localparam logic [10:0] OffsetTop =
    11'(((MAX_VALUE_BYTES - 1) < 2047) ? (MAX_VALUE_BYTES - 1) : 2047);

  localparam logic [1:0] PH_CODE  = 2'd0;
  localparam logic [1:0] PH_LEN   = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  localparam logic [1:0] SUB_TYPE = 2'd0;
  localparam logic [1:0] SUB_LEN  = 2'd1;
  localparam logic [1:0] SUB_DATA = 2'd2;

  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [10:0] off_r, off_nxt;
  logic [1:0]  sub_ph_r, sub_ph_nxt;
  logic [7:0]  sub_rem_r, sub_rem_nxt;
  logic        sub_bad_r, sub_bad_nxt;
  logic [255:0] vld_r;

  logic [10:0] len_mem [256];
  logic [10:0] len_rd_r;
  logic        mem_we;
  logic [10:0] mem_wd;

  logic        acc;
  logic        room;
  logic [7:0]  b;
  logic        np;
  logic [1:0]  n;
  res_t        res [MAX_RES];
  res_t        head;
  logic [11:0] sum;
  logic [10:0] start;
  logic        agent;

  assign b         = in_tdata;
  assign np        = in_tuser[0];
  assign in_tready = room;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    phase_nxt   = np ? PH_CODE : phase_r;
    code_nxt    = code_r;
    rem_nxt     = np ? 8'd0 : rem_r;
    off_nxt     = np ? 11'd0 : off_r;
    sub_ph_nxt  = np ? SUB_TYPE : sub_ph_r;
    sub_rem_nxt = np ? 8'd0 : sub_rem_r;
    sub_bad_nxt = np ? 1'b0 : sub_bad_r;
    mem_we      = 1'b0;
    mem_wd      = '0;
    sum         = '0;
    start       = '0;
    agent       = (code_r == CODE_AGENT);
    n           = 2'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = '0;
    end

    unique case (phase_nxt)
      PH_CODE: begin
        if (b == CODE_END) begin
          res[n].kind = KIND_VALID;
          n           = n + 2'd1;
          phase_nxt   = PH_DONE;
        end else if (b != CODE_PAD) begin
          code_nxt  = b;
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        rem_nxt = b;
        if (agent) begin
          off_nxt     = '0;
          sub_ph_nxt  = SUB_TYPE;
          sub_rem_nxt = '0;
          sub_bad_nxt = 1'b0;
          if (b == 8'd0) begin
            res[n].kind        = KIND_AGENT_END;
            res[n].option_code = CODE_AGENT;
            n                  = n + 2'd1;
          end
        end else begin
          // len_rd_r was read at this code on the previous accepted item
          start   = vld_r[code_r] ? len_rd_r : 11'd0;
          off_nxt = start;
          sum     = {1'b0, start} + {4'b0, b};
          mem_we  = 1'b1;
          mem_wd  = (sum > {1'b0, OffsetTop}) ? OffsetTop : sum[10:0];
        end
        phase_nxt = (b == 8'd0) ? PH_CODE : PH_VALUE;
      end
      PH_VALUE: begin
        res[n].kind         = agent ? KIND_AGENT : KIND_OPTION;
        res[n].option_code  = code_r;
        res[n].value_byte   = b;
        res[n].value_offset = off_nxt;
        n                   = n + 2'd1;
        sum     = {1'b0, off_nxt} + 12'd1;
        off_nxt = (sum > {1'b0, OffsetTop}) ? OffsetTop : sum[10:0];
        rem_nxt = rem_nxt - 8'd1;
        if (agent && !sub_bad_nxt) begin
          case (sub_ph_nxt)
            SUB_TYPE: begin
              if (rem_nxt == 8'd0) sub_bad_nxt = 1'b1;
              else sub_ph_nxt = SUB_LEN;
            end
            SUB_LEN: begin
              if (b > rem_nxt) begin
                sub_bad_nxt = 1'b1;
              end else if (b == 8'd0) begin
                sub_ph_nxt = SUB_TYPE;
              end else begin
                sub_rem_nxt = b;
                sub_ph_nxt  = SUB_DATA;
              end
            end
            default: begin
              sub_rem_nxt = sub_rem_nxt - 8'd1;
              if (sub_rem_nxt == 8'd0) sub_ph_nxt = SUB_TYPE;
            end
          endcase
        end
        if (rem_nxt == 8'd0) begin
          if (agent) begin
            res[n].kind            = KIND_AGENT_END;
            res[n].option_code     = CODE_AGENT;
            res[n].agent_malformed = sub_bad_nxt;
            n                      = n + 2'd1;
          end
          phase_nxt = PH_CODE;
        end
      end
      default: begin
      end
    endcase

    if (in_tlast) begin
      if (phase_nxt == PH_CODE) begin
        res[n].kind = KIND_VALID;
        n           = n + 2'd1;
      end else if (phase_nxt != PH_DONE) begin
        res[n].kind = KIND_INVALID;
        n           = n + 2'd1;
      end
      phase_nxt = PH_CODE;
    end

    if (n != 2'd0) begin
      res[n - 2'd1].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_CODE;
      code_r    <= '0;
      rem_r     <= '0;
      off_r     <= '0;
      sub_ph_r  <= SUB_TYPE;
      sub_rem_r <= '0;
      sub_bad_r <= 1'b0;
      vld_r     <= '0;
    end else if (acc) begin
      phase_r   <= phase_nxt;
      code_r    <= code_nxt;
      rem_r     <= rem_nxt;
      off_r     <= off_nxt;
      sub_ph_r  <= sub_ph_nxt;
      sub_rem_r <= sub_rem_nxt;
      sub_bad_r <= sub_bad_nxt;
      if (np) vld_r <= '0;
      else if (mem_we) vld_r[code_r] <= 1'b1;
    end
  end

  // Length table: read at every accepted byte, so the code byte prefetches the
  // entry used by the length byte. Writes happen only on length bytes, never
  // between that prefetch and its use.
  always_ff @(posedge clk) begin
    if (acc) begin
      len_rd_r <= len_mem[b];
      if (mem_we) len_mem[code_r] <= mem_wd;
    end
  end

  dotp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (acc ? n : 2'd0),
    .push_res   (res),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .head       (head)
  );

  assign out_tdata = {4'b0, head.agent_malformed, head.value_offset,
                      head.value_byte, head.option_code};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

// ===== rtl/core/dotp_checker.sv =====
// Port-level checks of the DHCP option TLV parser, bound to the top level.
module dotp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  import dotp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_VALID || out_tuser == KIND_INVALID) |-> out_tlast)
    else $error("buffer status is not the last result of its item");

  a_agent_end_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_AGENT_END |-> out_tdata[7:0] == CODE_AGENT
      && out_tdata[26:8] == 19'd0)
    else $error("agent end with wrong code or payload");

  a_malformed_only_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_AGENT_END |-> !out_tdata[27])
    else $error("malformed flag outside agent end");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= KIND_INVALID && out_tdata[31:28] == 4'd0)
    else $error("result kind out of range");

endmodule

bind dhcp_option_tlv_parser_top dotp_checker u_dotp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the DHCP option TLV parser: option byte streams vs. a predictor.
`timescale 1ns / 100ps

module tb_top;
  import dotp_pkg::*;

  localparam int OFF_TOP     = (MAX_VALUE_BYTES_DEF - 1 < 2047) ? MAX_VALUE_BYTES_DEF - 1 : 2047;
  localparam int STUCK_LIMIT = 1000;
  localparam int HOLD_AT     = 60;
  localparam int HOLD_LEN    = 64;
  localparam logic [7:0] COMMON_CODES [4] = '{8'd1, 8'd3, 8'd6, 8'd51};

  typedef enum logic [1:0] {PS_CODE, PS_LEN, PS_VALUE, PS_DONE} parse_phase_e;
  typedef enum logic [1:0] {SB_TYPE, SB_LEN, SB_DATA} sub_phase_e;

  typedef struct {
    logic [7:0] data;
    bit         np;
    bit         lb;
  } opt_byte_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata  = '0;
  logic [0:0]  in_tuser  = '0;
  logic        in_tlast  = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  dhcp_option_tlv_parser_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  opt_byte_t opt_bytes_q [$];
  res_t      tlv_res_q [$];
  int        n_pushed = 0;
  int        in_count = 0;
  int        err_cnt = 0;
  int        stuck_cyc = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  bit        holding = 1'b0;
  bit        quiet = 1'b0;
  res_t      got, want;

  // predictor state
  logic [10:0]  tot_len [256];
  bit           seen_code [256];
  parse_phase_e phase;
  logic [7:0]   cur_code;
  logic [7:0]   remaining;
  logic [10:0]  run_off;
  sub_phase_e   sub_ph;
  logic [7:0]   sub_left;
  bit           sub_bad;

  // random idling only in two of every three stretches, never near the end
  wire idle_zone = !quiet && ((in_count % 96) < 64);

  function automatic logic [10:0] offset_add(int a, int b);
    int s;
    s = a + b;
    return (s > OFF_TOP) ? 11'(OFF_TOP) : 11'(s);
  endfunction

  function automatic res_t make_res(logic [2:0] kind, logic [7:0] code, logic [7:0] val,
                                    logic [10:0] off, logic bad);
    res_t r;
    r = '{kind, code, val, off, bad, 1'b0};
    return r;
  endfunction

  task automatic tlv_parse_step(input logic [7:0] b, input bit np, input bit lb);
    res_t        res [$];
    logic [10:0] start;
    bit          agent;
    if (np) begin
      foreach (seen_code[i]) seen_code[i] = 1'b0;
      phase     = PS_CODE;
      remaining = '0;
      run_off   = '0;
      sub_ph    = SB_TYPE;
      sub_left  = '0;
      sub_bad   = 1'b0;
    end
    case (phase)
      PS_CODE: begin
        if (b == CODE_END) begin
          res.push_back(make_res(KIND_VALID, 8'd0, 8'd0, 11'd0, 1'b0));
          phase = PS_DONE;
        end else if (b != CODE_PAD) begin
          cur_code = b;
          phase = PS_LEN;
        end
      end
      PS_LEN: begin
        remaining = b;
        if (cur_code == CODE_AGENT) begin
          run_off  = '0;
          sub_ph   = SB_TYPE;
          sub_left = '0;
          sub_bad  = 1'b0;
          if (b == 8'd0) res.push_back(make_res(KIND_AGENT_END, CODE_AGENT, 8'd0, 11'd0, 1'b0));
        end else begin
          start = seen_code[cur_code] ? tot_len[cur_code] : 11'd0;
          run_off = start;
          tot_len[cur_code] = offset_add(start, b);
          seen_code[cur_code] = 1'b1;
        end
        phase = (b == 8'd0) ? PS_CODE : PS_VALUE;
      end
      PS_VALUE: begin
        agent = (cur_code == CODE_AGENT);
        res.push_back(make_res(agent ? KIND_AGENT : KIND_OPTION, cur_code, b, run_off, 1'b0));
        run_off = offset_add(run_off, 1);
        remaining = remaining - 8'd1;
        // sub-option walk; stops for good at the first overrun
        if (agent && !sub_bad) begin
          case (sub_ph)
            SB_TYPE: begin
              if (remaining == 8'd0) sub_bad = 1'b1;
              else sub_ph = SB_LEN;
            end
            SB_LEN: begin
              if (b > remaining) sub_bad = 1'b1;
              else if (b == 8'd0) sub_ph = SB_TYPE;
              else begin
                sub_left = b;
                sub_ph = SB_DATA;
              end
            end
            default: begin
              sub_left = sub_left - 8'd1;
              if (sub_left == 8'd0) sub_ph = SB_TYPE;
            end
          endcase
        end
        if (remaining == 8'd0) begin
          if (agent) res.push_back(make_res(KIND_AGENT_END, CODE_AGENT, 8'd0, 11'd0, sub_bad));
          phase = PS_CODE;
        end
      end
      default: ;
    endcase
    if (lb) begin
      if (phase == PS_CODE) res.push_back(make_res(KIND_VALID, 8'd0, 8'd0, 11'd0, 1'b0));
      else if (phase != PS_DONE) res.push_back(make_res(KIND_INVALID, 8'd0, 8'd0, 11'd0, 1'b0));
      phase = PS_CODE;
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) tlv_res_q.push_back(res[i]);
  endtask

  task automatic push_item(input logic [7:0] b, input bit np, input bit lb);
    opt_bytes_q.push_back('{data: b, np: np, lb: lb});
    n_pushed++;
  endtask

  task automatic add_option(ref logic [7:0] q [$], input logic [7:0] code, input int len);
    q.push_back(code);
    q.push_back(8'(len));
    repeat (len) q.push_back(8'($urandom));
  endtask

  // one packet of one or two buffers of well-formed records, with the odd broken tail
  task automatic add_packet();
    logic [7:0] buf_q [$];
    logic [7:0] sub_q [$];
    int  nbuf, n_rec, pick, len, term, cut, n_sub, sl, dl, k, r, s;
    bit  first, open_end;
    first = 1'b1;
    nbuf = ($urandom_range(0, 3) == 0) ? 2 : 1;
    for (k = 0; k < nbuf; k++) begin
      buf_q.delete();
      n_rec = $urandom_range(1, 5);
      for (r = 0; r < n_rec; r++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          buf_q.push_back(CODE_PAD);
        end else if (pick <= 2) begin
          sub_q.delete();
          n_sub = $urandom_range(0, 3);
          for (s = 0; s < n_sub; s++) begin
            sl = $urandom_range(0, 4);
            sub_q.push_back(8'($urandom_range(1, 255)));
            sub_q.push_back(8'(sl));
            repeat (sl) sub_q.push_back(8'($urandom));
          end
          case ($urandom_range(0, 5))
            0: sub_q.push_back(8'($urandom));  // lone sub type at the option end
            1: begin                           // sub length past the option end
              sl = $urandom_range(1, 6);
              dl = $urandom_range(0, sl - 1);
              sub_q.push_back(8'($urandom));
              sub_q.push_back(8'(sl));
              repeat (dl) sub_q.push_back(8'($urandom));
            end
            default: ;
          endcase
          buf_q.push_back(CODE_AGENT);
          buf_q.push_back(8'(sub_q.size()));
          foreach (sub_q[i]) buf_q.push_back(sub_q[i]);
        end else begin
          len = ($urandom_range(0, 15) == 0) ? $urandom_range(16, 255) : $urandom_range(0, 6);
          add_option(buf_q, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 254))
                                                        : COMMON_CODES[$urandom_range(0, 3)],
                     len);
        end
      end
      term = $urandom_range(0, 9);
      open_end = 1'b0;
      if (term <= 4) begin
        buf_q.push_back(CODE_END);
        repeat ($urandom_range(0, 3)) buf_q.push_back(8'($urandom));
      end else if (term >= 7) begin
        cut = $urandom_range(1, 3);
        while (cut > 0 && buf_q.size() > 1) begin
          void'(buf_q.pop_back());
          cut--;
        end
        // no buffer end at all: the next packet starts over the open record
        open_end = (term == 9);
      end
      foreach (buf_q[i]) push_item(buf_q[i], first && i == 0, !open_end && i == buf_q.size() - 1);
      first = 1'b0;
      if (open_end) break;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    int budget;
    bit sat_done;
    logic [7:0] sat_q [$];
    rst_n = 1'b0;
    budget = 310;
    sat_done = 1'b0;

    // pad, then a zero-length record closing the buffer
    push_item(CODE_PAD, 1, 0);
    push_item(8'd1, 0, 0);
    push_item(8'd0, 0, 1);
    // next buffer of the same packet: End, then ignored bytes up to the buffer end
    push_item(CODE_END, 0, 0);
    push_item(8'h55, 0, 1);
    // empty agent option, then a pad closing the buffer
    push_item(CODE_AGENT, 1, 0);
    push_item(8'd0, 0, 0);
    push_item(CODE_PAD, 0, 1);
    // agent sub type as the last option byte, buffer ends there too
    push_item(CODE_AGENT, 1, 0);
    push_item(8'd1, 0, 0);
    push_item(8'd5, 0, 1);
    // agent sub length past the option end
    push_item(CODE_AGENT, 1, 0);
    push_item(8'd3, 0, 0);
    push_item(8'd1, 0, 0);
    push_item(8'd7, 0, 0);
    push_item(8'hFF, 0, 1);
    // buffer ends on a code byte
    push_item(8'd200, 1, 1);
    // buffer ends inside a value
    push_item(8'd6, 1, 0);
    push_item(8'd2, 0, 0);
    push_item(8'hFF, 0, 1);
    // new packet in the middle of a record
    push_item(8'd50, 1, 0);
    push_item(8'd3, 0, 0);
    push_item(8'h01, 0, 0);
    push_item(8'd254, 1, 0);
    push_item(8'd1, 0, 0);
    push_item(8'h00, 0, 0);
    push_item(CODE_END, 0, 1);

    while (n_pushed < budget) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 8))
          push_item(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
      end else begin
        add_packet();
      end
      // one packet repeating a code until its offsets saturate; records cut short
      // by the buffer end right after their length still grow the stored total
      if (!sat_done && n_pushed > 150) begin
        sat_done = 1'b1;
        push_item(8'd9, 1, 0);
        push_item(8'd255, 0, 1);
        repeat (7) begin
          push_item(8'd9, 0, 0);
          push_item(8'd255, 0, 1);
        end
        add_option(sat_q, 8'd9, 12);
        sat_q.push_back(CODE_END);
        foreach (sat_q[i]) push_item(sat_q[i], 1'b0, i == sat_q.size() - 1);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (opt_bytes_q.size() > 0 || in_tvalid || tlv_res_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0 && tlv_res_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      in_tlast  <= 1'b0;
      gap_left   = 0;
      foreach (seen_code[i]) seen_code[i] = 1'b0;
      phase     = PS_CODE;
      cur_code  = '0;
      remaining = '0;
      run_off   = '0;
      sub_ph    = SB_TYPE;
      sub_left  = '0;
      sub_bad   = 1'b0;
      tlv_res_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        tlv_parse_step(in_tdata, in_tuser[0], in_tlast);
        in_count <= in_count + 1;
      end
      quiet <= (opt_bytes_q.size() < 40);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (opt_bytes_q.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (idle_zone && !holding && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 9);
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tdata  <= opt_bytes_q[0].data;
          in_tuser  <= opt_bytes_q[0].np;
          in_tlast  <= opt_bytes_q[0].lb;
          void'(opt_bytes_q.pop_front());
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off that backs up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && in_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN - 1;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_zone && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
      holding <= (hold_left > 0);
    end
  end

  // checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[7:0], out_tdata[15:8], out_tdata[26:16], out_tdata[27],
              out_tlast};
      if (tlv_res_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result kind %0d code %0d byte %0d offset %0d bad %0d last %0d",
                 $realtime, got.kind, got.option_code, got.value_byte, got.value_offset,
                 got.agent_malformed, got.last);
      end else begin
        want = tlv_res_q.pop_front();
        if (got !== want || out_tdata[31:28] !== 4'd0) begin
          err_cnt++;
          $display("%0t: expected kind %0d code %0d byte %0d offset %0d bad %0d last %0d",
                   $realtime, want.kind, want.option_code, want.value_byte, want.value_offset,
                   want.agent_malformed, want.last);
          $display("%0t:   actual kind %0d code %0d byte %0d offset %0d bad %0d last %0d tdata %h",
                   $realtime, got.kind, got.option_code, got.value_byte, got.value_offset,
                   got.agent_malformed, got.last, out_tdata);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cyc <= 0;
    end else if (stuck_cyc == STUCK_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $realtime, STUCK_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stuck_cyc <= stuck_cyc + 1;
    end
  end

endmodule
